// ===== sv/ebrs_pkg.sv =====
// Shared types and constants for the escaped byte run squeezer.
package ebrs_pkg;

  // Special characters of the escaped framing
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] ZERO_CHAR = 8'h30;

  // Result queue geometry
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  // Framing mode register values
  typedef enum logic {
    MODE_ESCAPED = 1'b0,
    MODE_PLAIN   = 1'b1
  } mode_e;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  // Results produced by one input byte: count plus up to two items
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } res_pair_t;

endpackage

// ===== sv/escaped_byte_run_squeezer_unit.sv =====
// Top level of the escaped byte run squeezer.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries one message
//   byte and its end flag per transaction. Output channel (out_valid_o /
//   out_ready_i / out_item_o) carries one squeezed byte with last and error.
//   cfg_we_i / cfg_wdata_i write the mode register (0 escaped, 1 plain);
//   write it only while no transaction is in flight.
// Path: an accepted byte sits in the input register, is resolved into the
//   result queue once the queue has room, and its first result is valid on
//   the output as soon as it has been written into the queue.
// Throughput: one byte per cycle. A byte yields zero, one or two results;
//   the four-entry result queue takes up to two results per cycle and drains one,
//   so input pauses only while the queue holds more than two results.
// Reset: clears the mode to escaped, empties the message state, the input
//   register and the result queue.
// Receiver stall: results wait in the queue; once it is too full to take
//   another byte's results, the input register holds and in_ready_o drops.
module escaped_byte_run_squeezer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ebrs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ebrs_pkg::out_item_t out_item_o
);

  ebrs_pkg::mode_e    mode_q;
  logic               in_vld_q, in_vld_d;
  ebrs_pkg::in_item_t in_q;
  ebrs_pkg::res_pair_t res;
  logic               room;
  logic               step;
  logic               in_acc;

  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || step;
  assign in_acc     = in_valid_i && in_ready_o;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ebrs_pkg::MODE_ESCAPED;
    end else if (cfg_we_i) begin
      mode_q <= ebrs_pkg::mode_e'(cfg_wdata_i);
    end
  end

  // Input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  ebrs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .mode_i (mode_q),
    .item_i (in_q),
    .res_o  (res)
  );

  ebrs_rq u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/ebrs_core.sv =====
// Run squeezing logic and per-message state for the escaped byte run squeezer.
module ebrs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ebrs_pkg::mode_e    mode_i,
  input  ebrs_pkg::in_item_t item_i,
  output ebrs_pkg::res_pair_t res_o
);

  logic [7:0] held_q, held_d;
  logic       have_q, have_d;
  logic       bs_before_q, bs_before_d;

  logic [7:0] b;
  logic       prev_bs;

  assign b       = item_i.data_byte;
  assign prev_bs = (held_q == ebrs_pkg::BACKSLASH);

  // Next state and results for the byte in the input register
  always_comb begin
    held_d      = held_q;
    have_d      = have_q;
    bs_before_d = bs_before_q;
    res_o       = '0;
    if (mode_i == ebrs_pkg::MODE_ESCAPED) begin
      if (!have_q) begin
        held_d      = b;
        have_d      = 1'b1;
        bs_before_d = 1'b0;
      end else if (prev_bs && (b == ebrs_pkg::ZERO_CHAR)) begin
        // terminator: emit both bytes and close the message
        res_o.num  = 2'd2;
        res_o.res0 = '{out_byte: ebrs_pkg::BACKSLASH, last: 1'b0, error: 1'b0};
        res_o.res1 = '{out_byte: ebrs_pkg::ZERO_CHAR, last: 1'b1, error: 1'b0};
        held_d      = '0;
        have_d      = 1'b0;
        bs_before_d = 1'b0;
      end else if (held_q != b) begin
        if (prev_bs && !bs_before_q) begin
          // lone backslash: error, drop this byte, restart
          res_o.num  = 2'd1;
          res_o.res0 = '{out_byte: 8'h00, last: 1'b1, error: 1'b1};
          held_d      = '0;
          have_d      = 1'b0;
          bs_before_d = 1'b0;
        end else begin
          if (prev_bs) begin
            // backslash run: one escaped pair
            res_o.num  = 2'd2;
            res_o.res0 = '{out_byte: ebrs_pkg::BACKSLASH, last: 1'b0, error: 1'b0};
            res_o.res1 = '{out_byte: ebrs_pkg::BACKSLASH, last: 1'b0, error: 1'b0};
          end else begin
            res_o.num  = 2'd1;
            res_o.res0 = '{out_byte: held_q, last: 1'b0, error: 1'b0};
          end
          bs_before_d = prev_bs;
          held_d      = b;
        end
      end else begin
        bs_before_d = prev_bs;
        held_d      = b;
      end
    end else begin
      // plain mode: end flag closes the message
      if (have_q) begin
        if (held_q != b) begin
          res_o.num  = 2'd1;
          res_o.res0 = '{out_byte: held_q, last: 1'b0, error: 1'b0};
        end
        bs_before_d = prev_bs;
      end else begin
        bs_before_d = 1'b0;
      end
      held_d = b;
      have_d = 1'b1;
      if (item_i.end_of_message) begin
        if (res_o.num == 2'd1) begin
          res_o.res1 = '{out_byte: b, last: 1'b1, error: 1'b0};
          res_o.num  = 2'd2;
        end else begin
          res_o.res0 = '{out_byte: b, last: 1'b1, error: 1'b0};
          res_o.num  = 2'd1;
        end
        held_d      = '0;
        have_d      = 1'b0;
        bs_before_d = 1'b0;
      end
    end
    if (!step_i) begin
      held_d      = held_q;
      have_d      = have_q;
      bs_before_d = bs_before_q;
      res_o.num   = 2'd0;
    end
  end

  // Message state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      have_q      <= 1'b0;
      bs_before_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      have_q      <= have_d;
      bs_before_q <= bs_before_d;
    end
  end

endmodule

// ===== sv/ebrs_rq.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
module ebrs_rq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebrs_pkg::res_pair_t res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ebrs_pkg::out_item_t out_item_o
);

  ebrs_pkg::out_item_t entry_q [ebrs_pkg::RQ_DEPTH];

  logic [ebrs_pkg::RQ_AW-1:0] wr_q, wr_d;
  logic [ebrs_pkg::RQ_AW-1:0] rd_q, rd_d;
  logic [ebrs_pkg::RQ_CW-1:0] cnt_q, cnt_d;
  logic [ebrs_pkg::RQ_AW-1:0] wr_nxt;
  logic                       pop;

  assign wr_nxt      = wr_q + 1'b1;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = entry_q[rd_q];
  // two free slots guaranteed, whatever leaves this cycle
  assign room_o      = (cnt_q <= ebrs_pkg::RQ_CW'(ebrs_pkg::RQ_DEPTH - 2));

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + ebrs_pkg::RQ_AW'(res_i.num);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + ebrs_pkg::RQ_CW'(res_i.num) - ebrs_pkg::RQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (res_i.num != 2'd0) begin
      entry_q[wr_q] <= res_i.res0;
    end
    if (res_i.num == 2'd2) begin
      entry_q[wr_nxt] <= res_i.res1;
    end
  end

endmodule
